### rtl/bmprd_pkg.sv
package bmprd_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FORMAT = 2'd2;

  // pixel format codes (code three decodes as 24 bpp)
  localparam logic [1:0] FMT_1BPP  = 2'd0;
  localparam logic [1:0] FMT_8BPP  = 2'd1;
  localparam logic [1:0] FMT_24BPP = 2'd2;

  // input word kinds (in_tuser)
  localparam logic KIND_PALETTE = 1'b0;
  localparam logic KIND_PIXEL   = 1'b1;

  localparam int CFG_W       = 13;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // one decoded input byte: up to eight pixels sharing row and start column
  typedef struct packed {
    logic [31:0] color0;    // color for a clear bit (or the only color)
    logic [31:0] color1;    // color for a set bit, 1 bpp only
    logic [7:0]  bits;      // 1 bpp pixel bits, MSB first; zero otherwise
    logic [2:0]  cnt_m1;    // pixel count minus one
    logic [11:0] col;       // column of the first pixel
    logic [11:0] row;       // top-down row
    logic        done_last; // last pixel closes the image
  } px_word_t;

endpackage

### rtl/bmprd_front.sv
module bmprd_front #(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wen,
  input  logic [1:0]                        cfg_addr,
  input  logic [bmprd_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bmprd_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                              in_tuser,
  output logic                              push,
  output bmprd_pkg::px_word_t               push_word,
  input  logic                              fifo_ready
);

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int RCW = $clog2(MAX_HEIGHT + 1);
  localparam int RBW = $clog2(3 * MAX_WIDTH + 4);
  localparam int PAW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  localparam logic [1:0] PH_B = 2'd0;
  localparam logic [1:0] PH_G = 2'd1;
  localparam logic [1:0] PH_R = 2'd2;

  // config: raw registers plus values derived at write time
  logic [bmprd_pkg::CFG_W-1:0] width_raw_r, width_raw_nxt;
  logic [bmprd_pkg::CFG_W-1:0] height_raw_r, height_raw_nxt;
  logic [1:0]                  fmt_r, fmt_nxt;
  logic [CW-1:0]               w_eff_r;
  logic [RCW-1:0]              h_eff_r;
  logic [RBW-1:0]              db_r, rb_r;
  logic [31:0]                 w32, h32, db32, rb32;

  // decode state
  logic [RCW-1:0] row_count_r, row_count_nxt;
  logic [CW-1:0]  col_r, col_nxt;
  logic [RBW-1:0] rbc_r, rbc_nxt, rbc_inc;
  logic [15:0]    partial_r, partial_nxt;
  logic [1:0]     phase_r, phase_nxt;
  logic           done_r, done_nxt;

  // palette
  logic [31:0] pal_mem [PALETTE_DEPTH];
  logic [31:0] pal_q_r, pal0_r, pal1_r;

  // stage between accept and queue
  logic        b_valid_r, b_valid_nxt;
  logic        b_use_pal_r, b_oob_r, b_done_r;
  logic [31:0] b_color_r, b_color1_r;
  logic [7:0]  b_bits_r;
  logic [2:0]  b_cnt_m1_r;
  logic [11:0] b_col_r, b_row_r;

  logic          acc, is_pix, stop, in_data, col_ok, row_end, take;
  logic [7:0]    pal_idx, dbyte;
  logic [31:0]   pal_val, color, color1;
  logic [7:0]    bits;
  logic          use_pal, done_last;
  logic [CW-1:0] left;
  logic [3:0]    n;
  logic [CW:0]   col_sum;

  assign pal_idx = in_tdata[7:0];
  assign pal_val = in_tdata[39:8];
  assign dbyte   = in_tdata[47:40];

  assign in_tready = !b_valid_r || fifo_ready;
  assign acc       = in_tvalid && in_tready;
  assign is_pix    = (in_tuser == bmprd_pkg::KIND_PIXEL);

  // config next values and derived row geometry
  always_comb begin
    width_raw_nxt  = width_raw_r;
    height_raw_nxt = height_raw_r;
    fmt_nxt        = fmt_r;
    if (cfg_wen) begin
      case (cfg_addr)
        bmprd_pkg::REG_WIDTH:  width_raw_nxt  = cfg_wdata;
        bmprd_pkg::REG_HEIGHT: height_raw_nxt = cfg_wdata;
        bmprd_pkg::REG_FORMAT: fmt_nxt        = cfg_wdata[1:0];
        default: ;
      endcase
    end
    w32 = 32'(width_raw_nxt);
    h32 = 32'(height_raw_nxt);
    if (w32 == 32'd0) w32 = 32'd1;
    else if (w32 > 32'(MAX_WIDTH)) w32 = 32'(MAX_WIDTH);
    if (h32 == 32'd0) h32 = 32'd1;
    else if (h32 > 32'(MAX_HEIGHT)) h32 = 32'(MAX_HEIGHT);
    case (fmt_nxt)
      bmprd_pkg::FMT_1BPP: db32 = (w32 + 32'd7) >> 3;
      bmprd_pkg::FMT_8BPP: db32 = w32;
      default:             db32 = (w32 << 1) + w32;
    endcase
    rb32 = (db32 + 32'd3) & ~32'd3;
  end

  // per-byte decode
  always_comb begin
    stop     = done_r || (row_count_r >= h_eff_r);
    in_data  = rbc_r < db_r;
    col_ok   = col_r < w_eff_r;
    left     = w_eff_r - col_r;
    rbc_inc  = rbc_r + RBW'(1);
    row_end  = rbc_inc >= rb_r;
    n        = 4'd0;
    color    = pal0_r;
    color1   = pal1_r;
    bits     = 8'd0;
    use_pal  = 1'b0;
    partial_nxt = partial_r;
    phase_nxt   = phase_r;
    case (fmt_r)
      bmprd_pkg::FMT_1BPP: begin
        bits = dbyte;
        if (in_data && col_ok) n = (left >= CW'(8)) ? 4'd8 : 4'(left);
      end
      bmprd_pkg::FMT_8BPP: begin
        use_pal = 1'b1;
        if (in_data && col_ok) n = 4'd1;
      end
      default: begin
        color = {8'h00, dbyte, partial_r};
        if (in_data) begin
          case (phase_r)
            PH_B: begin
              partial_nxt = {8'h00, dbyte};
              phase_nxt   = PH_G;
            end
            PH_G: begin
              partial_nxt = {dbyte, partial_r[7:0]};
              phase_nxt   = PH_R;
            end
            default: begin
              if (col_ok) n = 4'd1;
              partial_nxt = 16'h0000;
              phase_nxt   = PH_B;
            end
          endcase
        end
      end
    endcase
    col_sum   = (CW+1)'(col_r) + (CW+1)'(n);
    done_last = (col_sum == (CW+1)'(w_eff_r)) && ((row_count_r + RCW'(1)) == h_eff_r);
    take      = acc && is_pix && !stop;

    row_count_nxt = row_count_r;
    col_nxt       = col_r;
    rbc_nxt       = rbc_r;
    done_nxt      = done_r;
    if (acc && is_pix && stop) begin
      done_nxt    = 1'b1;
      partial_nxt = partial_r;
      phase_nxt   = phase_r;
    end else if (take) begin
      col_nxt = CW'(col_sum);
      rbc_nxt = rbc_inc;
      if (row_end) begin
        rbc_nxt       = '0;
        col_nxt       = '0;
        partial_nxt   = 16'h0000;
        phase_nxt     = PH_B;
        row_count_nxt = row_count_r + RCW'(1);
        if ((row_count_r + RCW'(1)) >= h_eff_r) done_nxt = 1'b1;
      end
    end else begin
      partial_nxt = partial_r;
      phase_nxt   = phase_r;
    end

    b_valid_nxt = b_valid_r;
    if (push) b_valid_nxt = 1'b0;
    if (take && (n != 4'd0)) b_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_raw_r  <= bmprd_pkg::CFG_W'(1);
      height_raw_r <= bmprd_pkg::CFG_W'(1);
      fmt_r        <= bmprd_pkg::FMT_24BPP;
      w_eff_r      <= CW'(1);
      h_eff_r      <= RCW'(1);
      db_r         <= RBW'(3);
      rb_r         <= RBW'(4);
      row_count_r  <= '0;
      col_r        <= '0;
      rbc_r        <= '0;
      partial_r    <= 16'h0000;
      phase_r      <= PH_B;
      done_r       <= 1'b0;
      b_valid_r    <= 1'b0;
    end else begin
      width_raw_r  <= width_raw_nxt;
      height_raw_r <= height_raw_nxt;
      fmt_r        <= fmt_nxt;
      w_eff_r      <= CW'(w32);
      h_eff_r      <= RCW'(h32);
      db_r         <= RBW'(db32);
      rb_r         <= RBW'(rb32);
      row_count_r  <= row_count_nxt;
      col_r        <= col_nxt;
      rbc_r        <= rbc_nxt;
      partial_r    <= partial_nxt;
      phase_r      <= phase_nxt;
      done_r       <= done_nxt;
      b_valid_r    <= b_valid_nxt;
    end
  end

  // palette RAM, plus shadow copies of slots 0/1 for 1 bpp
  always_ff @(posedge clk) begin
    if (acc && !is_pix && ({1'b0, pal_idx} < 9'(PALETTE_DEPTH))) begin
      pal_mem[PAW'(pal_idx)] <= pal_val;
    end
    if (acc && is_pix) begin
      pal_q_r <= pal_mem[PAW'(dbyte)];
    end
    if (acc && !is_pix && (pal_idx == 8'd0)) pal0_r <= pal_val;
    if (acc && !is_pix && (pal_idx == 8'd1)) pal1_r <= pal_val;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      b_use_pal_r <= use_pal;
      b_oob_r     <= {1'b0, dbyte} >= 9'(PALETTE_DEPTH);
      b_color_r   <= color;
      b_color1_r  <= color1;
      b_bits_r    <= bits;
      b_cnt_m1_r  <= 3'(n - 4'd1);
      b_col_r     <= 12'(col_r);
      b_row_r     <= 12'(h_eff_r - RCW'(1) - row_count_r);
      b_done_r    <= done_last;
    end
  end

  assign push = b_valid_r && fifo_ready;

  always_comb begin
    push_word.color0    = b_use_pal_r ? (b_oob_r ? 32'd0 : pal_q_r) : b_color_r;
    push_word.color1    = b_color1_r;
    push_word.bits      = b_bits_r;
    push_word.cnt_m1    = b_cnt_m1_r;
    push_word.col       = b_col_r;
    push_word.row       = b_row_r;
    push_word.done_last = b_done_r;
  end

endmodule

### rtl/bmprd_fifo.sv
module bmprd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  bmprd_pkg::px_word_t push_word,
  output logic                ready,
  input  logic                pop,
  output logic                not_empty,
  output bmprd_pkg::px_word_t pop_word
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  bmprd_pkg::px_word_t mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign ready     = cnt_r != (AW+1)'(DEPTH);
  assign not_empty = cnt_r != '0;
  assign pop_word  = mem[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + (AW+1)'(1);
    else if (pop && !push) cnt_nxt = cnt_r - (AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + AW'(1);
      if (pop) rp_r <= rp_r + AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_word;
  end

endmodule

### rtl/bmprd_back.sv
module bmprd_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               not_empty,
  input  bmprd_pkg::px_word_t                pop_word,
  output logic                               pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bmprd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                               out_tlast,
  output logic                               out_tuser
);

  bmprd_pkg::px_word_t cur_r;
  logic       cur_valid_r, cur_valid_nxt;
  logic [2:0] k_r;
  logic       out_valid_r, out_valid_nxt;
  logic       adv, emit, last;
  logic [31:0] color;

  assign adv   = !out_valid_r || out_tready;
  assign emit  = adv && cur_valid_r;
  assign last  = (k_r == cur_r.cnt_m1);
  assign pop   = not_empty && (!cur_valid_r || (emit && last));
  // MSB first: pixel k takes bit 7-k
  assign color = cur_r.bits[~k_r] ? cur_r.color1 : cur_r.color0;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    if (emit && last) cur_valid_nxt = 1'b0;
    if (pop) cur_valid_nxt = 1'b1;
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= 3'd0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (pop) k_r <= 3'd0;
      else if (emit) k_r <= k_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur_r <= pop_word;
    if (emit) begin
      out_tdata <= {cur_r.row, cur_r.col + 12'(k_r), color};
      out_tlast <= last;
      out_tuser <= last && cur_r.done_last;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

### rtl/bmp_pixel_row_decoder_top.sv
// BMP pixel-array decoder. Palette words (in_tuser = 0) load one 32-bit entry;
// pixel words (in_tuser = 1) carry one byte of the pixel array, row padding
// included, decoded as 1 bpp, 8 bpp or 24 bpp BGR per the format register.
// Rows come bottom-up, so the first row out is height-1. Input side takes one
// word per clock while in_tready is high; a 1 bpp byte fans out to up to eight
// pixels, and the output side produces at most one pixel per clock, so 1 bpp
// input runs at 1/n words per clock (n = pixels in that byte) once the 4-deep
// queue fills. A byte passes front stage, queue, current word, output register.
// Config writes take effect on the next clock and belong between images.
module bmp_pixel_row_decoder_top #(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // config: 0 image_width, 1 image_height, 2 pixel_format
  input  logic                               cfg_wen,
  input  logic [1:0]                         cfg_addr,
  input  logic [bmprd_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [7:0] palette_index, [39:8] palette_value, [47:40] data_byte
  input  logic [bmprd_pkg::IN_TDATA_W-1:0]   in_tdata,
  // kind: 0 palette write, 1 pixel byte
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] blue, [15:8] green, [23:16] red, [31:24] reserved_byte,
  // [43:32] column, [55:44] row
  output logic [bmprd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // last_in_run: last pixel of this input byte
  output logic                               out_tlast,
  // image_done: final pixel of the image
  output logic                               out_tuser
);

  logic                push, fifo_ready, pop, not_empty;
  bmprd_pkg::px_word_t push_word, pop_word;

  // front: config, palette RAM, byte decode, row/column tracking
  bmprd_front #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push       (push),
    .push_word  (push_word),
    .fifo_ready (fifo_ready)
  );

  // queue of decoded bytes between front and back
  bmprd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .ready     (fifo_ready),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_word  (pop_word)
  );

  // back: one pixel per clock into the output register while out_tready allows
  bmprd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .not_empty  (not_empty),
    .pop_word   (pop_word),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
